### hdl/multi_level_crossing_counter_assert.svh
// Assertion macros for the port-level crossing counter checker.
`ifndef MULTI_LEVEL_CROSSING_COUNTER_ASSERT_SVH
`define MULTI_LEVEL_CROSSING_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define MLCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crossing counter check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define MLCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crossing counter check failed");

`endif

### hdl/mlcc_pkg.sv
// Types, constants and register codes of the multi-level crossing counter.
`default_nettype none
package mlcc_pkg;

  localparam int NUM_LEVELS  = 8;
  localparam int SAMPLE_BITS = 14;
  localparam int COUNT_BITS  = 32;
  localparam int STEP_BITS   = 11;
  localparam int WINDOW_BITS = 12;
  localparam int PAIR_BITS   = 13;
  localparam int CFG_DATA_BITS = 14;
  localparam int CFG_IDX_BITS  = 2;

  // Wide enough for the highest threshold plus one more step.
  localparam int LEVEL_W = $clog2((1 << SAMPLE_BITS) + NUM_LEVELS * (1 << STEP_BITS));

  // Cycles for a new threshold setting to ripple down the whole row.
  localparam int SETTLE_CYCLES = NUM_LEVELS + 1;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  localparam logic [SAMPLE_BITS-1:0] FIRST_LEVEL_RST  = SAMPLE_BITS'(3400);
  localparam logic [STEP_BITS-1:0]   LEVEL_STEP_RST   = STEP_BITS'(50);
  localparam logic [WINDOW_BITS-1:0] WINDOW_PAIRS_RST = WINDOW_BITS'(1750);
  localparam logic [PAIR_BITS-1:0]   PAIR_MAX         = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FIRST_LEVEL  = 2'd0,
    REG_LEVEL_STEP   = 2'd1,
    REG_WINDOW_PAIRS = 2'd2
  } mlcc_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   wave_start;
  } mlcc_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count_l0;
    logic [COUNT_BITS-1:0] count_l1;
    logic [COUNT_BITS-1:0] count_l2;
    logic [COUNT_BITS-1:0] count_l3;
    logic [COUNT_BITS-1:0] count_l4;
    logic [COUNT_BITS-1:0] count_l5;
    logic [COUNT_BITS-1:0] count_l6;
    logic [COUNT_BITS-1:0] count_l7;
    logic [NUM_LEVELS-1:0] crossed_mask;
  } mlcc_out_t;

  // Beat pushed from the counting row into the output buffer.
  typedef struct packed {
    logic      valid;
    mlcc_out_t data;
  } mlcc_push_t;

endpackage
`default_nettype wire

### hdl/mlcc_cell.sv
// One threshold cell: holds its level and count, passes the next level on.
`default_nettype none
module mlcc_cell
  import mlcc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [LEVEL_W-1:0]     level_in,
  input  wire logic [STEP_BITS-1:0]   level_step,
  output logic      [LEVEL_W-1:0]     level_out,
  input  wire logic                   check,
  input  wire logic [SAMPLE_BITS-1:0] prev_sample,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        crossed,
  output logic      [COUNT_BITS-1:0]  count_nxt
);

  logic [LEVEL_W-1:0]    level_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [LEVEL_W-1:0]    p_ext;
  logic [LEVEL_W-1:0]    s_ext;

  assign p_ext = {{(LEVEL_W-SAMPLE_BITS){1'b0}}, prev_sample};
  assign s_ext = {{(LEVEL_W-SAMPLE_BITS){1'b0}}, sample};

  // The neighbor's threshold is this one plus one step.
  assign level_out = level_r + {{(LEVEL_W-STEP_BITS){1'b0}}, level_step};

  assign crossed = check && (((p_ext < level_r) && (s_ext > level_r)) ||
                             ((p_ext > level_r) && (s_ext < level_r)));

  always_comb begin
    count_nxt = count_r;
    if (crossed && (count_r != '1)) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/mlcc_out_buf.sv
// Output register with a skid entry; input waits on out_stall only while the skid is full.
`default_nettype none
module mlcc_out_buf
  import mlcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mlcc_push_t push,
  output logic            full,
  output logic            out_valid,
  input  wire logic       out_stall,
  output mlcc_out_t       out_payload
);

  logic      out_valid_r;
  logic      skid_valid_r;
  mlcc_out_t out_r;
  mlcc_out_t skid_r;
  logic      out_fire;

  assign out_fire    = out_valid_r && !out_stall;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;
  assign full        = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push.valid) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (push.valid) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= push.data;
      end else begin
        out_r <= push.data;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/multi_level_crossing_counter.sv
// Top level of the multi-level crossing counter: control, cell row, output buffer.
//
//   channel  direction  handshake          beat
//   in_      input      in_valid/in_stall  mlcc_in_t  (sample, wave_start)
//   out_     output     out_valid/out_stall mlcc_out_t (eight counts, crossed_mask)
//   cfg_     input      cfg_valid/cfg_ready index + data, ready always high
//
// One input beat per cycle while in_stall is low; its result beat is registered in the
// output register, or, while that register holds a stalled beat, in a skid entry.
// The eight cells compare and count in parallel; thresholds ripple down the row one
// cell per cycle, so after reset or a register write input is held off until they
// reach the last cell. in_stall rises while the skid entry is occupied or thresholds settle.
`default_nettype none
module multi_level_crossing_counter
  import mlcc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire mlcc_in_t                 in_payload,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output mlcc_out_t                     out_payload,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [SAMPLE_BITS-1:0] first_level_r;
  logic [STEP_BITS-1:0]   level_step_r;
  logic [WINDOW_BITS-1:0] window_pairs_r;
  logic [SETTLE_W-1:0]    settle_r;
  logic [SAMPLE_BITS-1:0] prev_r;
  logic [PAIR_BITS-1:0]   pair_r;
  logic [PAIR_BITS-1:0]   pair_nxt;

  logic       accept;
  logic       check;
  logic       buf_full;
  logic       cfg_wr;
  mlcc_push_t push;

  logic [LEVEL_W-1:0]    level_chain [NUM_LEVELS+1];
  logic [COUNT_BITS-1:0] count_nxt   [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] crossed;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = buf_full || (settle_r != '0);
  assign accept    = in_valid && !in_stall;
  assign check     = accept && !in_payload.wave_start &&
                     (pair_r < {1'b0, window_pairs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_level_r  <= FIRST_LEVEL_RST;
      level_step_r   <= LEVEL_STEP_RST;
      window_pairs_r <= WINDOW_PAIRS_RST;
    end else if (cfg_wr) begin
      case (mlcc_reg_t'(cfg_index))
        REG_FIRST_LEVEL:  first_level_r  <= cfg_data[SAMPLE_BITS-1:0];
        REG_LEVEL_STEP:   level_step_r   <= cfg_data[STEP_BITS-1:0];
        REG_WINDOW_PAIRS: window_pairs_r <= cfg_data[WINDOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hold off input until new thresholds have reached the last cell.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SETTLE_W'(1);
    end
  end

  always_comb begin
    pair_nxt = pair_r;
    if (accept && in_payload.wave_start) begin
      pair_nxt = '0;
    end else if (check && (pair_r != PAIR_MAX)) begin
      pair_nxt = pair_r + PAIR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pair_r <= '0;
    end else begin
      pair_r <= pair_nxt;
      if (accept) begin
        prev_r <= in_payload.sample;
      end
    end
  end

  assign level_chain[0] = {{(LEVEL_W-SAMPLE_BITS){1'b0}}, first_level_r};

  for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_cell
    mlcc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .level_in    (level_chain[i]),
      .level_step  (level_step_r),
      .level_out   (level_chain[i+1]),
      .check       (check),
      .prev_sample (prev_r),
      .sample      (in_payload.sample),
      .crossed     (crossed[i]),
      .count_nxt   (count_nxt[i])
    );
  end

  always_comb begin
    push.valid             = accept;
    push.data.count_l0     = count_nxt[0];
    push.data.count_l1     = count_nxt[1];
    push.data.count_l2     = count_nxt[2];
    push.data.count_l3     = count_nxt[3];
    push.data.count_l4     = count_nxt[4];
    push.data.count_l5     = count_nxt[5];
    push.data.count_l6     = count_nxt[6];
    push.data.count_l7     = count_nxt[7];
    push.data.crossed_mask = crossed;
  end

  mlcc_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (buf_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule
`default_nettype wire

### hdl/mlcc_checker.sv
// Port-level checks of the crossing counter, bound to the top level.
`default_nettype none
`include "multi_level_crossing_counter_assert.svh"
module mlcc_checker
  import mlcc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire mlcc_in_t  in_payload,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire mlcc_out_t out_payload
);

  logic start_in;
  logic no_cross;
  logic hit_l0;

  assign start_in = in_valid && !in_stall && !out_valid && in_payload.wave_start;
  assign no_cross = out_valid && (out_payload.crossed_mask == '0);
  assign hit_l0   = out_valid && out_payload.crossed_mask[0];

  // A stalled result beat stays offered and unchanged.
  `MLCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `MLCC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_payload))

  // A crossing just counted at level 0 leaves that count above zero.
  `MLCC_ASSERT_NOW(a_mask_count, hit_l0, out_payload.count_l0 != '0)

  // With the output empty, a waveform's first sample shows up next cycle with no crossings.
  `MLCC_ASSERT_NEXT(a_start_no_cross, start_in, no_cross)

endmodule

bind multi_level_crossing_counter mlcc_checker u_mlcc_checker (.*);
`default_nettype wire

### tb/sv/crossing_checker.sv
// Checker for the crossing counter: predicts each result beat and compares it with the block.
`timescale 1ns / 100ps
module crossing_checker
  import mlcc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  mlcc_in_t                 in_payload,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  mlcc_out_t                out_payload,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatches,
  output int                       pending
);

  logic [SAMPLE_BITS-1:0] base_level;
  logic [STEP_BITS-1:0]   spacing;
  logic [WINDOW_BITS-1:0] window;

  logic [SAMPLE_BITS-1:0] prev_sample;
  logic [PAIR_BITS-1:0]   pairs_seen;
  logic [COUNT_BITS-1:0]  counts [NUM_LEVELS];

  mlcc_out_t expected_counts [$];

  task automatic report_mismatch(input string what, input logic [COUNT_BITS-1:0] got,
                                 input logic [COUNT_BITS-1:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [COUNT_BITS-1:0] got,
                             input logic [COUNT_BITS-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Advances the predicted state by one sample beat and returns the result it causes.
  function automatic mlcc_out_t count_crossings(input mlcc_in_t beat);
    mlcc_out_t res;
    logic [NUM_LEVELS-1:0] hit;
    int lvl;
    int i;
    hit = '0;
    if (beat.wave_start) begin
      pairs_seen = '0;
    end else if (pairs_seen < window) begin
      for (i = 0; i < NUM_LEVELS; i++) begin
        // Thresholds are formed at full width, so the upper ones may lie past any sample.
        lvl = int'(base_level) + int'(spacing) * i;
        if ((int'(prev_sample) < lvl && int'(beat.sample) > lvl) ||
            (int'(prev_sample) > lvl && int'(beat.sample) < lvl)) begin
          hit[i] = 1'b1;
          if (counts[i] != '1) counts[i] = counts[i] + COUNT_BITS'(1);
        end
      end
      if (pairs_seen != PAIR_MAX) pairs_seen = pairs_seen + PAIR_BITS'(1);
    end
    prev_sample = beat.sample;
    res.count_l0 = counts[0];
    res.count_l1 = counts[1];
    res.count_l2 = counts[2];
    res.count_l3 = counts[3];
    res.count_l4 = counts[4];
    res.count_l5 = counts[5];
    res.count_l6 = counts[6];
    res.count_l7 = counts[7];
    res.crossed_mask = hit;
    return res;
  endfunction

  always @(posedge clk) begin
    mlcc_out_t want;
    int i;
    if (!rst_n) begin
      base_level = FIRST_LEVEL_RST;
      spacing = LEVEL_STEP_RST;
      window = WINDOW_PAIRS_RST;
      prev_sample = '0;
      pairs_seen = '0;
      for (i = 0; i < NUM_LEVELS; i++) counts[i] = '0;
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_LEVEL:  base_level = cfg_data[SAMPLE_BITS-1:0];
          REG_LEVEL_STEP:   spacing = cfg_data[STEP_BITS-1:0];
          REG_WINDOW_PAIRS: window = cfg_data[WINDOW_BITS-1:0];
          default: ;
        endcase
      end
      // Queue the new sample first, so the comparison holds whatever the latency.
      if (in_valid && !in_stall) expected_counts.push_back(count_crossings(in_payload));
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("result beat with nothing expected", '0, '0);
        end else begin
          want = expected_counts.pop_front();
          check_field("count_l0", out_payload.count_l0, want.count_l0);
          check_field("count_l1", out_payload.count_l1, want.count_l1);
          check_field("count_l2", out_payload.count_l2, want.count_l2);
          check_field("count_l3", out_payload.count_l3, want.count_l3);
          check_field("count_l4", out_payload.count_l4, want.count_l4);
          check_field("count_l5", out_payload.count_l5, want.count_l5);
          check_field("count_l6", out_payload.count_l6, want.count_l6);
          check_field("count_l7", out_payload.count_l7, want.count_l7);
          check_field("crossed_mask", COUNT_BITS'(out_payload.crossed_mask),
                      COUNT_BITS'(want.crossed_mask));
        end
      end
    end
    pending = expected_counts.size();
  end

endmodule

### tb/sv/testbench.sv
// Top of the crossing counter testbench: clock, reset, sample and register stimulus, verdict.
`timescale 1ns / 100ps
module testbench;
  import mlcc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 8;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 123;
  localparam int SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  mlcc_in_t                 in_payload;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  mlcc_out_t                out_payload;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int mismatches;
  int pending;
  int sent;
  int idle_cycles;
  int level_base;
  int level_gap;
  int last_sample;
  bit calm;
  bit hold_pending = 1'b1;
  bit hold_active;

  multi_level_crossing_counter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  crossing_checker crossing_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, plus one long hold-off that backs the block up.
  always begin
    @(posedge clk);
    if (hold_pending && sent >= HOLD_AT) begin
      hold_pending = 1'b0;
      hold_active = 1'b1;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  task automatic send(input int value, input logic start);
    if (!calm && !hold_active && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= '{sample: value[SAMPLE_BITS-1:0], wave_start: start};
    do @(posedge clk); while (in_stall);
    last_sample = value;
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Settings change only once every result of the previous phase is back.
  task automatic configure(input logic [CFG_DATA_BITS-1:0] base,
                           input logic [CFG_DATA_BITS-1:0] step,
                           input logic [CFG_DATA_BITS-1:0] window);
    drain();
    write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
    write_reg(REG_FIRST_LEVEL, base);
    write_reg(REG_LEVEL_STEP, step);
    write_reg(REG_WINDOW_PAIRS, window);
    cfg_valid <= 1'b0;
    level_base = int'(base[SAMPLE_BITS-1:0]);
    level_gap = int'(step[STEP_BITS-1:0]);
  endtask

  // Mostly aims near a threshold so that crossings and exact hits are frequent.
  function automatic int pick_sample();
    int v;
    int lvl;
    lvl = level_base + level_gap * int'($urandom_range(0, NUM_LEVELS - 1));
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, SAMPLE_TOP));
      2: v = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
      3: v = lvl;
      4: v = last_sample + int'($urandom_range(0, 6)) - 3;
      default: v = lvl + int'($urandom_range(0, 2 * level_gap + 8)) - level_gap - 4;
    endcase
    if (v < 0) v = 0;
    else if (v > SAMPLE_TOP) v = SAMPLE_TOP;
    return v;
  endfunction

  initial begin
    int phase;
    int items;
    int wave_len;
    int k;
    logic start;
    logic [CFG_DATA_BITS-1:0] base;
    logic [CFG_DATA_BITS-1:0] step;
    logic [CFG_DATA_BITS-1:0] window;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    last_sample = 0;
    calm = 1'b0;
    level_base = int'(FIRST_LEVEL_RST);
    level_gap = int'(LEVEL_STEP_RST);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Default thresholds 3400..3750. The first samples come before any waveform start.
    send(3425, 1'b0);
    send(SAMPLE_TOP, 1'b0);
    send(0, 1'b0);
    send(3400, 1'b0);
    send(3500, 1'b0);
    send(3600, 1'b1);
    send(3300, 1'b0);
    send(3750, 1'b0);
    send(3750, 1'b0);
    send(0, 1'b1);
    send(SAMPLE_TOP, 1'b1);
    send(0, 1'b0);

    // An empty window: nothing may be counted.
    configure('0, '0, '0);
    send(5, 1'b1);
    send(9, 1'b0);
    send(0, 1'b0);

    // Thresholds at and beyond the top of the sample range.
    configure(CFG_DATA_BITS'(SAMPLE_TOP), 14'd2047, 14'd1);
    send(SAMPLE_TOP, 1'b1);
    send(0, 1'b0);
    send(SAMPLE_TOP, 1'b0);

    // A two-pair window that fills up partway through the waveform.
    configure(14'd100, 14'd1, 14'd2);
    send(90, 1'b1);
    send(110, 1'b0);
    send(90, 1'b0);
    send(110, 1'b0);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin base = 14'd3350; step = 14'd50; window = 14'd1750; end
        1: begin base = '0; step = '0; window = 14'd4095; end
        2: begin base = CFG_DATA_BITS'(SAMPLE_TOP); step = 14'd2047; window = '0; end
        3: begin base = 14'd8000; step = 14'd2047; window = 14'd30; end
        4: begin base = '0; step = 14'd2047; window = 14'd12; end
        default: begin
          base = CFG_DATA_BITS'($urandom_range(0, SAMPLE_TOP));
          // Upper data bits beyond each register's width are junk that must be dropped.
          step = {3'($urandom), 11'($urandom_range(0, 400))};
          window = {2'($urandom), 12'($urandom_range(0, 40))};
        end
      endcase
      if (phase == NUM_PHASES - 1) calm = 1'b1;
      configure(base, step, window);
      items = 0;
      while (items < PHASE_ITEMS) begin
        wave_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        for (k = 0; k < wave_len && items < PHASE_ITEMS; k++) begin
          start = (k == 0);
          // Now and then a stray start or a missing one.
          if ($urandom_range(0, 19) == 0) start = ~start;
          send(pick_sample(), start);
          items++;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
